// ===== rtl/time_wait_connection_table_macros.svh =====
// Assertion macros for the time-wait connection table.
`ifndef TIME_WAIT_CONNECTION_TABLE_MACROS_SVH
`define TIME_WAIT_CONNECTION_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define TWCT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TWCT_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWCT_ASSERT(label, clk, rst_n, prop, msg)
`define TWCT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/twct_pkg.sv =====
// Package with types, codes and constants of the time-wait connection table.
`default_nettype none
package twct_pkg;
  localparam int TableDepth = 32;
  localparam logic [15:0] PeriodReset = 16'd5;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_PKT   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  localparam logic [3:0] ST_ADDED      = 4'd0;
  localparam logic [3:0] ST_REPLACED   = 4'd1;
  localparam logic [3:0] ST_FULL       = 4'd2;
  localparam logic [3:0] ST_NO_REPLY   = 4'd3;
  localparam logic [3:0] ST_SEND_CLOSE = 4'd4;
  localparam logic [3:0] ST_SEND_RESET = 4'd5;
  localparam logic [3:0] ST_NOT_FOUND  = 4'd6;
  localparam logic [3:0] ST_FOUND      = 4'd7;
  localparam logic [3:0] ST_EXPIRED    = 4'd8;
  localparam logic [3:0] ST_TICK_DONE  = 4'd9;

  localparam logic CFG_PERIOD = 1'b0;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] conn_key;
    logic [7:0]  version;
    logic        has_close_packet;
    logic [47:0] packet_number;
    logic [15:0] reply_tag;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] result_id;
    logic [7:0]  result_version;
    logic [31:0] packet_count;
    logic [47:0] rejected_number;
    logic [15:0] reply_tag_out;
    logic        last;
  } out_word_t;
endpackage
`default_nettype wire

// ===== rtl/twct_stream_if.sv =====
// Valid/ready channel interface carrying one payload word.
`default_nettype none
interface twct_stream_if #(parameter type word_t = logic) (input wire logic clk);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/twct_front.sv =====
// Front part: a two-word queue toward the table engine.
`default_nettype none
module twct_front (
  input  wire logic clk,
  input  wire logic rst_n,
  twct_stream_if.sink   in_s,
  twct_stream_if.source q_s
);
  twct_pkg::in_word_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_s.ready = (cnt_r != 2'd2);
  assign push = in_s.valid && in_s.ready;
  assign pop  = q_s.valid && q_s.ready;
  assign q_s.valid = (cnt_r != 2'd0);
  assign q_s.data  = mem_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_s.data;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "time_wait_connection_table_macros.svh"
  `TWCT_ASSERT(a_no_overflow, clk, rst_n, (cnt_r == 2'd2) |-> !push, "queue overflow")
  `TWCT_ASSERT(a_cnt_range, clk, rst_n, cnt_r != 2'd3, "queue count out of range")
  `TWCT_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> (cnt_r != 2'd0), "pop from empty queue")
endmodule
`default_nettype wire

// ===== rtl/twct_engine.sv =====
// Back part: table storage, parallel key match, and the tick expiry sweep.
`default_nettype none
module twct_engine #(
  parameter int TABLE_DEPTH = twct_pkg::TableDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [15:0] period,
  twct_stream_if.sink   q_s,
  twct_stream_if.source out_s
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [63:0] key_r   [TABLE_DEPTH];
  logic [7:0]  ver_r   [TABLE_DEPTH];
  logic        close_r [TABLE_DEPTH];
  logic [31:0] count_r [TABLE_DEPTH];
  logic [31:0] stamp_r [TABLE_DEPTH];
  logic [31:0] time_r;

  logic [1:0] state_r;
  twct_pkg::in_word_t cur_r;
  logic [IW-1:0] idx_r;
  logic hit_r, free_any_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  twct_pkg::out_word_t ob_r;
  logic ov_r;

  logic [TABLE_DEPTH-1:0] match;
  logic hit_c, free_c;
  logic [IW-1:0] hit_idx_c, free_idx_c;
  logic out_free;
  logic [31:0] cinc, age;
  logic expire_c, load_c;
  twct_pkg::out_word_t res_c;

  assign out_free = !ov_r || out_s.ready;
  assign out_s.valid = ov_r;
  assign out_s.data = ob_r;
  assign q_s.ready = (state_r == S_IDLE);

  // Parallel key compare and lowest free slot.
  always_comb begin
    hit_c = 1'b0;
    free_c = 1'b0;
    hit_idx_c = '0;
    free_idx_c = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (key_r[i] == cur_r.conn_key);
      if (match[i]) begin
        hit_c = 1'b1;
        hit_idx_c = IW'(i);
      end
      if (!valid_r[i]) begin
        free_c = 1'b1;
        free_idx_c = IW'(i);
      end
    end
  end

  assign cinc = (count_r[hit_idx_r] == 32'hFFFF_FFFF) ? count_r[hit_idx_r]
                                                     : count_r[hit_idx_r] + 32'd1;
  assign age = time_r - stamp_r[idx_r];
  assign expire_c = valid_r[idx_r] && (age >= {16'd0, period});

  // Result word for the current step; the tick-done word closes the sweep.
  always_comb begin
    res_c = '0;
    res_c.reply_tag_out = cur_r.reply_tag;
    load_c = 1'b0;
    case (state_r)
      S_EXEC: begin
        load_c = 1'b1;
        res_c.result_id = cur_r.conn_key;
        res_c.last = 1'b1;
        case (cur_r.action)
          twct_pkg::ACT_ADD: begin
            if (hit_r) begin
              res_c.status = twct_pkg::ST_REPLACED;
              res_c.result_version = cur_r.version;
              res_c.packet_count = count_r[hit_idx_r];
            end else if (free_any_r) begin
              res_c.status = twct_pkg::ST_ADDED;
              res_c.result_version = cur_r.version;
            end else begin
              res_c.status = twct_pkg::ST_FULL;
            end
          end
          twct_pkg::ACT_TICK: begin
            res_c.status = twct_pkg::ST_TICK_DONE;
            res_c.result_id = '0;
          end
          twct_pkg::ACT_QUERY: begin
            if (!hit_r) begin
              res_c.status = twct_pkg::ST_NOT_FOUND;
            end else begin
              res_c.status = twct_pkg::ST_FOUND;
              res_c.result_version = ver_r[hit_idx_r];
              res_c.packet_count = count_r[hit_idx_r];
            end
          end
          default: begin
            if (!hit_r) begin
              res_c.status = twct_pkg::ST_NOT_FOUND;
            end else begin
              res_c.result_version = ver_r[hit_idx_r];
              res_c.packet_count = cinc;
              if ((cinc & (cinc - 32'd1)) != 32'd0)
                res_c.status = twct_pkg::ST_NO_REPLY;
              else if (close_r[hit_idx_r])
                res_c.status = twct_pkg::ST_SEND_CLOSE;
              else begin
                res_c.status = twct_pkg::ST_SEND_RESET;
                res_c.rejected_number = cur_r.packet_number;
              end
            end
          end
        endcase
      end
      S_SWEEP: begin
        load_c = expire_c;
        res_c.status = twct_pkg::ST_EXPIRED;
        res_c.result_id = key_r[idx_r];
        res_c.result_version = ver_r[idx_r];
        res_c.packet_count = count_r[idx_r];
      end
      default: load_c = 1'b0;
    endcase
  end

  // Table writes.
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && out_free) begin
      if (cur_r.action == twct_pkg::ACT_ADD && hit_r) begin
        ver_r[hit_idx_r] <= cur_r.version;
        close_r[hit_idx_r] <= cur_r.has_close_packet;
        stamp_r[hit_idx_r] <= time_r;
      end else if (cur_r.action == twct_pkg::ACT_ADD && free_any_r) begin
        key_r[free_idx_r] <= cur_r.conn_key;
        ver_r[free_idx_r] <= cur_r.version;
        close_r[free_idx_r] <= cur_r.has_close_packet;
        count_r[free_idx_r] <= '0;
        stamp_r[free_idx_r] <= time_r;
      end else if (cur_r.action == twct_pkg::ACT_PKT && hit_r) begin
        count_r[hit_idx_r] <= cinc;
      end
    end
  end

  // Control, output register, valid bits and time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      time_r <= '0;
      ov_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load_c && out_free) begin
        ov_r <= 1'b1;
        ob_r <= res_c;
      end else if (out_s.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_s.valid) begin
            cur_r <= q_s.data;
            if (q_s.data.action == twct_pkg::ACT_TICK) begin
              time_r <= time_r + 32'd1;
              idx_r <= '0;
              state_r <= S_SWEEP;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          hit_r <= hit_c;
          hit_idx_r <= hit_idx_c;
          free_any_r <= free_c;
          free_idx_r <= free_idx_c;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            state_r <= S_IDLE;
            if (cur_r.action == twct_pkg::ACT_ADD && !hit_r && free_any_r)
              valid_r[free_idx_r] <= 1'b1;
          end
        end
        S_SWEEP: begin
          if (out_free) begin
            if (expire_c) valid_r[idx_r] <= 1'b0;
            if (idx_r == LastIdx) begin
              state_r <= S_EXEC;
            end else begin
              idx_r <= idx_r + IW'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "time_wait_connection_table_macros.svh"
  `TWCT_ASSERT(a_one_hit, clk, rst_n, (state_r == S_DONE) |-> $onehot0(match), "duplicate key")
  `TWCT_ASSERT(a_take_idle, clk, rst_n, (q_s.valid && q_s.ready) |-> (state_r == S_IDLE), "busy take")
  `TWCT_ASSERT(a_hold, clk, rst_n, (ov_r && !out_s.ready) |=> (ov_r && $stable(ob_r)), "result lost")
endmodule
`default_nettype wire

// ===== rtl/time_wait_connection_table.sv =====
// Top level of the time-wait connection table.
// An add, packet or query word goes through state DONE (match registered), then EXEC,
// where its result is registered. The engine takes a new word only when idle.
// The tick sweep visits one slot per cycle on the shared age compare, if out_s is free.
// Reset (rst_n low, synchronous) empties the table, clears time and sets the period to 5.
`default_nettype none
module time_wait_connection_table #(
  parameter int TABLE_DEPTH = twct_pkg::TableDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  twct_stream_if.sink   in_s,
  twct_stream_if.source out_s,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [15:0] period_r;

  twct_stream_if #(.word_t(twct_pkg::in_word_t)) q_if (.clk(clk));

  // Register port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1] == twct_pkg::CFG_PERIOD) ? {16'd0, period_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= twct_pkg::PeriodReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[1] == twct_pkg::CFG_PERIOD) begin
      period_r <= cfg_pwdata[15:0];
    end
  end

  twct_front u_front (.clk(clk), .rst_n(rst_n), .in_s(in_s), .q_s(q_if.source));
  twct_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk(clk), .rst_n(rst_n), .period(period_r), .q_s(q_if.sink), .out_s(out_s)
  );
endmodule
`default_nettype wire

// ===== verif/time_wait_connection_table_tb.sv =====
// Testbench for the time-wait connection table: random and directed words checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

module time_wait_connection_table_tb;

  // Scoreboard holding a software copy of the table and the expected result words.
  class conn_table_scoreboard;
    bit          slot_used[twct_pkg::TableDepth];
    logic [63:0] slot_key[twct_pkg::TableDepth];
    logic [7:0]  slot_ver[twct_pkg::TableDepth];
    bit          slot_close[twct_pkg::TableDepth];
    logic [31:0] slot_count[twct_pkg::TableDepth];
    logic [31:0] slot_stamp[twct_pkg::TableDepth];
    logic [31:0] now;
    logic [15:0] period;
    twct_pkg::out_word_t pending[$];
    int          errors;

    function void clear();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      now = '0;
      period = twct_pkg::PeriodReset;
      pending.delete();
      errors = 0;
    endfunction

    function int lookup(logic [63:0] key);
      for (int i = 0; i < twct_pkg::TableDepth; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function void push(logic [3:0] st, logic [63:0] id, logic [7:0] ver, logic [31:0] cnt,
                       logic [47:0] rej, logic [15:0] tag, bit lst);
      twct_pkg::out_word_t w;
      w.status = st; w.result_id = id; w.result_version = ver; w.packet_count = cnt;
      w.rejected_number = rej; w.reply_tag_out = tag; w.last = lst;
      pending = {pending, w};
    endfunction

    // Work out the result words that one accepted input word causes.
    function void note_input(twct_pkg::in_word_t w);
      int s;
      logic [31:0] c;
      s = lookup(w.conn_key);
      case (w.action)
        twct_pkg::ACT_ADD: begin
          if (s >= 0) begin
            slot_ver[s] = w.version; slot_close[s] = w.has_close_packet; slot_stamp[s] = now;
            push(twct_pkg::ST_REPLACED, w.conn_key, w.version, slot_count[s], '0,
                 w.reply_tag, 1'b1);
          end else begin
            for (int i = 0; i < twct_pkg::TableDepth; i++)
              if (!slot_used[i]) begin s = i; break; end
            if (s < 0) begin
              push(twct_pkg::ST_FULL, w.conn_key, '0, '0, '0, w.reply_tag, 1'b1);
            end else begin
              slot_used[s] = 1'b1; slot_key[s] = w.conn_key; slot_ver[s] = w.version;
              slot_close[s] = w.has_close_packet; slot_count[s] = '0; slot_stamp[s] = now;
              push(twct_pkg::ST_ADDED, w.conn_key, w.version, '0, '0, w.reply_tag, 1'b1);
            end
          end
        end
        twct_pkg::ACT_PKT: begin
          if (s < 0) begin
            push(twct_pkg::ST_NOT_FOUND, w.conn_key, '0, '0, '0, w.reply_tag, 1'b1);
          end else begin
            c = slot_count[s];
            if (c != 32'hFFFF_FFFF) c = c + 32'd1;
            slot_count[s] = c;
            if ((c & (c - 32'd1)) != 32'd0)
              push(twct_pkg::ST_NO_REPLY, w.conn_key, slot_ver[s], c, '0, w.reply_tag, 1'b1);
            else if (slot_close[s])
              push(twct_pkg::ST_SEND_CLOSE, w.conn_key, slot_ver[s], c, '0, w.reply_tag,
                   1'b1);
            else
              push(twct_pkg::ST_SEND_RESET, w.conn_key, slot_ver[s], c, w.packet_number,
                   w.reply_tag, 1'b1);
          end
        end
        twct_pkg::ACT_QUERY: begin
          if (s < 0)
            push(twct_pkg::ST_NOT_FOUND, w.conn_key, '0, '0, '0, w.reply_tag, 1'b1);
          else
            push(twct_pkg::ST_FOUND, w.conn_key, slot_ver[s], slot_count[s], '0,
                 w.reply_tag, 1'b1);
        end
        default: begin
          now = now + 32'd1;
          for (int i = 0; i < twct_pkg::TableDepth; i++)
            if (slot_used[i] && (now - slot_stamp[i]) >= {16'd0, period}) begin
              slot_used[i] = 1'b0;
              push(twct_pkg::ST_EXPIRED, slot_key[i], slot_ver[i], slot_count[i], '0,
                   w.reply_tag, 1'b0);
            end
          push(twct_pkg::ST_TICK_DONE, '0, '0, '0, '0, w.reply_tag, 1'b1);
        end
      endcase
    endfunction

    // Compare one result word with the oldest expectation, field by field.
    function void check_result(twct_pkg::out_word_t got);
      twct_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected result word status=%0d id=%h", got.status, got.result_id);
        errors++;
        return;
      end
      exp_w = pending[0];
      pending.delete(0);
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status); errors++;
      end
      if (got.result_id !== exp_w.result_id) begin
        $error("result_id: expected %h, got %h", exp_w.result_id, got.result_id); errors++;
      end
      if (got.result_version !== exp_w.result_version) begin
        $error("result_version: expected %h, got %h", exp_w.result_version,
               got.result_version); errors++;
      end
      if (got.packet_count !== exp_w.packet_count) begin
        $error("packet_count: expected %h, got %h", exp_w.packet_count, got.packet_count);
        errors++;
      end
      if (got.rejected_number !== exp_w.rejected_number) begin
        $error("rejected_number: expected %h, got %h", exp_w.rejected_number,
               got.rejected_number); errors++;
      end
      if (got.reply_tag_out !== exp_w.reply_tag_out) begin
        $error("reply_tag_out: expected %h, got %h", exp_w.reply_tag_out,
               got.reply_tag_out); errors++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, got.last); errors++;
      end
    endfunction
  endclass

  localparam int CycleLimit = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  twct_stream_if #(.word_t(twct_pkg::in_word_t))  in_ch (clk);
  twct_stream_if #(.word_t(twct_pkg::out_word_t)) out_ch (clk);

  time_wait_connection_table u_top (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_s(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  conn_table_scoreboard table_model = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  logic [63:0] key_pool[8];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check every accepted result word and randomly stall the receiver.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) table_model.check_result(out_ch.data);
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[time_wait_connection_table] ERROR");
      $finish;
    end
  end

  // Write the period register through a setup and an access cycle.
  task automatic write_period(logic [15:0] value);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {twct_pkg::CFG_PERIOD, 1'b0}; cfg_pwdata <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    table_model.period = value;
  endtask

  // Drive one input word, with a random idle gap before it; valid stays up between words unless a gap drops it.
  task automatic send_word(twct_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    table_model.note_input(w);
  endtask

  task automatic send_fields(logic [1:0] act, logic [63:0] id, logic [7:0] ver, bit cls,
                             logic [47:0] pnum);
    twct_pkg::in_word_t w;
    w.action = act; w.conn_key = id; w.version = ver; w.has_close_packet = cls;
    w.packet_number = pnum; w.reply_tag = 16'($urandom);
    send_word(w);
  endtask

  // Drop valid, wait until every expected word has come, then let the engine settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (table_model.pending.size() != 0) @(posedge clk);
    repeat (twct_pkg::TableDepth + 10) @(posedge clk);
  endtask

  // Random word biased toward a small pool of keys so entries are revisited.
  task automatic send_random();
    twct_pkg::in_word_t w;
    int r;
    r = $urandom_range(99);
    w.action = (r < 30) ? twct_pkg::ACT_ADD : (r < 70) ? twct_pkg::ACT_PKT :
               (r < 85) ? twct_pkg::ACT_QUERY : twct_pkg::ACT_TICK;
    w.conn_key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)]
                                         : {$urandom, $urandom};
    w.version = 8'($urandom);
    w.has_close_packet = 1'($urandom);
    w.packet_number = 48'({$urandom, $urandom});
    w.reply_tag = 16'($urandom);
    send_word(w);
  endtask

  initial begin
    bit failed;
    logic [15:0] periods[4];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    table_model.clear();
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme keys, every action, close and reset replies, replace.
    send_fields(twct_pkg::ACT_QUERY, 64'd0, 8'd0, 1'b0, 48'd0);
    send_fields(twct_pkg::ACT_PKT, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b0, 48'd0);
    send_fields(twct_pkg::ACT_ADD, 64'd0, 8'hFF, 1'b0, 48'd0);
    send_fields(twct_pkg::ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_fields(twct_pkg::ACT_PKT, 64'd0, 8'd0, 1'b0, 48'hFFFF_FFFF_FFFF);
    send_fields(twct_pkg::ACT_PKT, 64'd0, 8'd0, 1'b0, 48'h1234_5678_9ABC);
    send_fields(twct_pkg::ACT_PKT, 64'd0, 8'd0, 1'b0, 48'd7);
    send_fields(twct_pkg::ACT_PKT, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b0, 48'd1);
    send_fields(twct_pkg::ACT_ADD, 64'd0, 8'h5A, 1'b1, 48'd0);
    send_fields(twct_pkg::ACT_QUERY, 64'd0, 8'd0, 1'b0, 48'd0);
    send_fields(twct_pkg::ACT_PKT, 64'd0, 8'd0, 1'b0, 48'd3);
    send_fields(twct_pkg::ACT_TICK, 64'd0, 8'd0, 1'b0, 48'd0);
    // Fill the table past its depth to reach the full case.
    for (int i = 0; i < twct_pkg::TableDepth; i++)
      send_fields(twct_pkg::ACT_ADD, {$urandom, $urandom}, 8'($urandom), 1'($urandom), 48'd0);
    repeat (6) send_fields(twct_pkg::ACT_TICK, 64'd0, 8'd0, 1'b0, 48'd0);
    drain();

    // Random phases across several periods and idling patterns.
    periods[0] = 16'd1; periods[1] = 16'hFFFF; periods[2] = 16'd3; periods[3] = 16'd8;
    for (int ph = 0; ph < 4; ph++) begin
      write_period(periods[ph]);
      send_idle_pct = (ph == 1) ? 74 : (ph == 3) ? 33 : 0;
      recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 33 : 0;
      for (int n = 0; n < 40; n++) send_random();
      if (ph == 1) begin
        for (int i = 0; i < twct_pkg::TableDepth + 1; i++)
          send_fields(twct_pkg::ACT_ADD, {$urandom, $urandom}, 8'($urandom), 1'b0, 48'd0);
      end
      drain();
    end

    failed = (table_model.errors != 0) || (table_model.pending.size() != 0);
    if (!failed) begin
      $display("[time_wait_connection_table] OK");
    end else begin
      $display("[time_wait_connection_table] ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/twct_pkg.sv
rtl/twct_stream_if.sv
rtl/twct_front.sv
rtl/twct_engine.sv
rtl/time_wait_connection_table.sv
verif/time_wait_connection_table_tb.sv
